>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/b64le_pkg.sv
package b64le_pkg;

	localparam logic [7:0] LINE_WIDTH_RESET = 8'd76;
	localparam logic [6:0] NEWLINE_CODE = 7'd10;
	localparam logic [6:0] PAD_CODE = 7'd61;
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       end_of_message;
	} char_item_t;

	// One encoding job: a group of up to three bytes and how to print it.
	typedef struct packed {
		logic [23:0] word;
		logic [2:0]  n_sym;
		logic        nl;
		logic        eom;
	} job_t;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) begin
			c = 7'd65 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'd97 + {1'b0, v} - 7'd26;
		end else if (v < 6'd62) begin
			c = 7'd48 + {1'b0, v} - 7'd52;
		end else if (v == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/base64_line_encoder_top.sv
// The byte that ends a group puts its job in the queue, which feeds the output register.
// Throughput: one character per cycle from the output register while a job waits and
// char_ready is high; a byte is taken each cycle while the two-job queue has room, so
// the character port sets the sustained rate (four or five characters per three bytes).
// Reset clears the held bytes, column and queue, and sets the line width to 76.
module base64_line_encoder_top #(
	parameter int QUEUE_DEPTH = b64le_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  b64le_pkg::byte_item_t byte_item,
	output logic                  char_valid,
	input  logic                  char_ready,
	output b64le_pkg::char_item_t char_item
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	b64le_pkg::job_t push_job;
	b64le_pkg::job_t head_job;

	b64le_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	b64le_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	b64le_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.q_empty    (q_empty),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item)
	);

endmodule

>>> hw/rtl/b64le_front.sv
module b64le_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  b64le_pkg::byte_item_t byte_item,
	input  logic                  q_full,
	output logic                  push,
	output b64le_pkg::job_t       job
);

	logic [7:0]  line_width_q;
	logic [15:0] pending_q;
	logic [1:0]  fill_q;
	logic [7:0]  column_q;

	logic        accept;
	logic [8:0]  col_next;
	logic        wrap;
	logic [15:0] pending_d;
	logic [1:0]  fill_d;
	logic [7:0]  column_d;

	assign byte_ready = !q_full;
	assign accept = byte_valid && byte_ready;
	assign col_next = {1'b0, column_q} + 9'd4;
	assign wrap = (col_next >= {1'b0, line_width_q}) || col_next[8];

	always_comb begin
		push = 1'b0;
		job.word = {pending_q, byte_item.data_byte};
		job.n_sym = 3'd4;
		job.nl = 1'b0;
		job.eom = byte_item.final_byte;
		pending_d = pending_q;
		fill_d = fill_q;
		column_d = column_q;
		if (accept) begin
			if (fill_q[1]) begin
				push = 1'b1;
				job.nl = wrap || byte_item.final_byte;
				pending_d = '0;
				fill_d = '0;
				column_d = (wrap || byte_item.final_byte) ? 8'd0 : col_next[7:0];
			end else if (byte_item.final_byte) begin
				push = 1'b1;
				job.nl = 1'b1;
				if (fill_q[0]) begin
					job.word = {pending_q[7:0], byte_item.data_byte, 8'd0};
					job.n_sym = 3'd3;
				end else begin
					job.word = {byte_item.data_byte, 16'd0};
					job.n_sym = 3'd2;
				end
				pending_d = '0;
				fill_d = '0;
				column_d = '0;
			end else begin
				pending_d = {pending_q[7:0], byte_item.data_byte};
				fill_d = fill_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= b64le_pkg::LINE_WIDTH_RESET;
			pending_q <= '0;
			fill_q <= '0;
			column_q <= '0;
		end else begin
			if (cfg_we) begin
				line_width_q <= cfg_wdata;
			end
			pending_q <= pending_d;
			fill_q <= fill_d;
			column_q <= column_d;
		end
	end

endmodule

>>> hw/rtl/b64le_fifo.sv
module b64le_fifo #(
	parameter int DEPTH = b64le_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  b64le_pkg::job_t push_job,
	input  logic            pop,
	output b64le_pkg::job_t head_job,
	output logic            full,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	b64le_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/b64le_back.sv
module b64le_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64le_pkg::job_t       head_job,
	input  logic                  q_empty,
	output logic                  pop,
	output logic                  char_valid,
	input  logic                  char_ready,
	output b64le_pkg::char_item_t char_item
);

	logic [2:0]            idx_q;
	logic                  char_valid_q;
	b64le_pkg::char_item_t char_q;

	logic       load;
	logic       last;
	logic [5:0] sext;
	logic [6:0] ch;

	assign load = (!char_valid_q || char_ready) && !q_empty;
	assign last = head_job.nl ? (idx_q == 3'd4) : (idx_q == 3'd3);
	assign pop = load && last;

	always_comb begin
		case (idx_q[1:0])
			2'd0: sext = head_job.word[23:18];
			2'd1: sext = head_job.word[17:12];
			2'd2: sext = head_job.word[11:6];
			default: sext = head_job.word[5:0];
		endcase
		if (idx_q[2]) begin
			ch = b64le_pkg::NEWLINE_CODE;
		end else if (idx_q < head_job.n_sym) begin
			ch = b64le_pkg::b64_char(sext);
		end else begin
			ch = b64le_pkg::PAD_CODE;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q.out_char <= ch;
			char_q.end_of_message <= head_job.eom && last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			char_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
				char_valid_q <= 1'b1;
			end else if (char_ready) begin
				char_valid_q <= 1'b0;
			end
		end
	end

	assign char_valid = char_valid_q;
	assign char_item = char_q;

endmodule

>>> hw/rtl/b64le_checker.sv
`include "assert_macros.svh"

module b64le_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input b64le_pkg::byte_item_t byte_item,
	input logic                  char_valid,
	input logic                  char_ready,
	input b64le_pkg::char_item_t char_item
);

	logic [6:0] c;
	logic       legal;
	logic       fin_taken;

	assign c = char_item.out_char;
	assign legal = (c == b64le_pkg::NEWLINE_CODE) || (c == b64le_pkg::PAD_CODE)
		|| (c == 7'd43) || (c == 7'd47)
		|| ((c >= 7'd65) && (c <= 7'd90)) || ((c >= 7'd97) && (c <= 7'd122))
		|| ((c >= 7'd48) && (c <= 7'd57));
	assign fin_taken = byte_valid && byte_ready && byte_item.final_byte;

	`ASSERT_NEXT(a_char_held, char_valid && !char_ready, char_valid)
	`ASSERT_NOW(a_char_legal, char_valid, legal)
	`ASSERT_NOW(a_eom_newline, char_valid && char_item.end_of_message, c == b64le_pkg::NEWLINE_CODE)
	`ASSERT_NEXT(a_fin_output, fin_taken, ##1 char_valid)

endmodule

bind base64_line_encoder_top b64le_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.byte_item  (byte_item),
	.char_valid (char_valid),
	.char_ready (char_ready),
	.char_item  (char_item)
);
